### rtl/core/itf_pkg.sv
// Package: payload types, flag bit indices, character codes, controller/datapath command and status structs.
`timescale 1ns / 1ps
`default_nettype none
package itf_pkg;
	typedef struct packed {
		logic [31:0] magnitude;
		logic        non_negative;
		logic [5:0]  radix;
		logic [6:0]  format_flags;
		logic [5:0]  field_width;
		logic [5:0]  min_digits;
		logic [15:0] start_pos;
	} in_beat_t;

	typedef struct packed {
		logic [6:0]  out_char;
		logic [15:0] out_pos;
		logic        last_char;
	} out_beat_t;

	localparam int unsigned FL_LEFT  = 0;
	localparam int unsigned FL_ZERO  = 1;
	localparam int unsigned FL_PLUS  = 2;
	localparam int unsigned FL_SPACE = 3;
	localparam int unsigned FL_HASH  = 4;
	localparam int unsigned FL_PREC  = 5;
	localparam int unsigned FL_UPPER = 6;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_LA    = 7'h61;
	localparam logic [6:0] CH_UA    = 7'h41;
	localparam logic [6:0] CH_LX    = 7'h78;
	localparam logic [6:0] CH_UX    = 7'h58;
	localparam logic [6:0] CH_LB    = 7'h62;
	localparam logic [6:0] CH_MINUS = 7'h2d;
	localparam logic [6:0] CH_PLUS  = 7'h2b;
	localparam logic [6:0] CH_SPACE = 7'h20;

	typedef struct packed {
		logic load;       // latch request
		logic div_start;  // start one digit division
		logic push_digit; // store division remainder
		logic pad_step;   // one padding/prefix/sign step
		logic emit_init;  // compute totals
		logic emit_step;  // advance output index
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic digits_done;
		logic pad_done;
		logic emit_last;
	} dp_sts_t;
endpackage
`default_nettype wire

### rtl/core/integer_to_text_formatter.sv
// Top level: printf-style integer to text formatter.
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | itf_pkg::in_beat_t
//  out     | out | out_valid / out_ready | itf_pkg::out_beat_t
// One request at a time. Each digit comes from one division in the bit-serial divider
// (up to BUFFER_SIZE digits, a zero magnitude gives a single '0' without division),
// then padding, the S_INIT and S_FETCH setup states, and one character per cycle
// while out_ready holds. Reset clears only control state.
// A stalled output holds its beat; no new request is taken until the last beat.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_text_formatter #(
	parameter int unsigned BUFFER_SIZE = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire itf_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output itf_pkg::out_beat_t      out_data
);
	itf_pkg::dp_cmd_t cmd;
	itf_pkg::dp_sts_t sts;

	itf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.zero_mag(in_data.magnitude == 32'd0), .sts(sts), .cmd(cmd)
	);

	itf_datapath #(.BUFFER_SIZE(BUFFER_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cmd(cmd), .sts(sts), .beat(out_data)
	);
endmodule
`default_nettype wire

### rtl/core/itf_divider.sv
// Radix-restoring divider: 32-bit dividend by 6-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module itf_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [5:0]  divisor,
	output logic             done,
	output logic [31:0]      quotient,
	output logic [5:0]       remainder
);
	logic [31:0] quo_q;
	logic [5:0]  rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [6:0]  trial;

	assign trial = {rem_q, quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= 6'(trial - {1'b0, divisor});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[5:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

### rtl/core/itf_datapath.sv
// Datapath: request registers, digit buffer, padding and emission counters.
`timescale 1ns / 1ps
`default_nettype none
module itf_datapath #(
	parameter int unsigned BUFFER_SIZE = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire itf_pkg::in_beat_t req,
	input  wire itf_pkg::dp_cmd_t  cmd,
	output itf_pkg::dp_sts_t       sts,
	output itf_pkg::out_beat_t     beat
);
	localparam int unsigned LW = $clog2(BUFFER_SIZE + 1);
	localparam int unsigned AW = $clog2(BUFFER_SIZE);
	localparam logic [LW-1:0] BSZ = LW'(BUFFER_SIZE);

	logic [31:0] mag_q;
	logic        neg_q;
	logic [5:0]  base_q;
	logic [6:0]  fl_q;
	logic [5:0]  width_q;
	logic [5:0]  prec_q;
	logic [15:0] pos_q;
	logic [LW-1:0] len_q;
	logic [2:0]  phase_q;
	logic [6:0]  pre_q;
	logic [6:0]  total_q;
	logic [6:0]  k_q;
	logic [6:0]  mem [BUFFER_SIZE];
	logic [6:0]  rd_q;
	logic        wr_en;
	logic [6:0]  wr_ch;
	logic        div_done;
	logic [31:0] quo;
	logic [5:0]  rem;
	logic [5:0]  base_c;
	logic [5:0]  width_eff;
	logic        sign_c;
	logic [6:0]  dch;
	logic [6:0]  kmp;
	logic [6:0]  next_k;
	logic [6:0]  ridx;

	always_comb begin
		if (req.radix < 6'd2)       base_c = 6'd2;
		else if (req.radix > 6'd36) base_c = 6'd36;
		else                         base_c = req.radix;
	end

	itf_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(mag_q),
		.divisor(base_q), .done(div_done), .quotient(quo), .remainder(rem)
	);

	assign sign_c = neg_q || fl_q[itf_pkg::FL_PLUS] || fl_q[itf_pkg::FL_SPACE];
	assign width_eff = (!fl_q[itf_pkg::FL_LEFT] && width_q != 6'd0 && fl_q[itf_pkg::FL_ZERO]
		&& sign_c) ? width_q - 6'd1 : width_q;

	always_comb begin
		if (rem < 6'd10)                  dch = itf_pkg::CH_ZERO + 7'(rem);
		else if (fl_q[itf_pkg::FL_UPPER]) dch = itf_pkg::CH_UA + 7'(rem) - 7'd10;
		else                              dch = itf_pkg::CH_LA + 7'(rem) - 7'd10;
	end

	// padding phases: 0 prec zeros, 1 zero pad, 2 hash trim, 3 hash letter,
	// 4 hash zero, 5 sign, 6 done
	logic [LW-1:0] len_n;
	logic [2:0]    phase_n;
	always_comb begin
		len_n   = len_q;
		phase_n = phase_q;
		wr_en   = 1'b0;
		wr_ch   = itf_pkg::CH_ZERO;
		if (cmd.push_digit) begin
			wr_en = 1'b1;
			// zero magnitude pushes a single '0'
			wr_ch = (mag_q == 32'd0) ? itf_pkg::CH_ZERO : dch;
			len_n = len_q + LW'(1);
		end else if (cmd.pad_step) begin
			case (phase_q)
				3'd0: begin
					if (!fl_q[itf_pkg::FL_LEFT] && 7'(len_q) < 7'(prec_q) && len_q < BSZ) begin
						wr_en = 1'b1;
						len_n = len_q + LW'(1);
					end else phase_n = 3'd1;
				end
				3'd1: begin
					if (!fl_q[itf_pkg::FL_LEFT] && fl_q[itf_pkg::FL_ZERO]
						&& 7'(len_q) < 7'(width_eff) && len_q < BSZ) begin
						wr_en = 1'b1;
						len_n = len_q + LW'(1);
					end else phase_n = fl_q[itf_pkg::FL_HASH] ? 3'd2 : 3'd5;
				end
				3'd2: begin
					phase_n = 3'd3;
					if (!fl_q[itf_pkg::FL_PREC] && len_q != '0 && (7'(len_q) == 7'(prec_q)
						|| 7'(len_q) == 7'(width_eff))) begin
						if (len_q != LW'(1) && base_q == 6'd16) len_n = len_q - LW'(2);
						else                                    len_n = len_q - LW'(1);
					end
				end
				3'd3: begin
					phase_n = 3'd4;
					if (base_q == 6'd16 && len_q < BSZ) begin
						wr_en = 1'b1;
						wr_ch = fl_q[itf_pkg::FL_UPPER] ? itf_pkg::CH_UX : itf_pkg::CH_LX;
						len_n = len_q + LW'(1);
					end else if (base_q == 6'd2 && len_q < BSZ) begin
						wr_en = 1'b1;
						wr_ch = itf_pkg::CH_LB;
						len_n = len_q + LW'(1);
					end
				end
				3'd4: begin
					phase_n = 3'd5;
					if (len_q < BSZ) begin
						wr_en = 1'b1;
						len_n = len_q + LW'(1);
					end
				end
				3'd5: begin
					phase_n = 3'd6;
					if (len_q < BSZ && sign_c) begin
						wr_en = 1'b1;
						wr_ch = neg_q ? itf_pkg::CH_MINUS :
							(fl_q[itf_pkg::FL_PLUS] ? itf_pkg::CH_PLUS : itf_pkg::CH_SPACE);
						len_n = len_q + LW'(1);
					end
				end
				default: phase_n = 3'd6;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[len_q[AW-1:0]] <= wr_ch;
		rd_q <= mem[ridx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			phase_q <= '0;
			k_q     <= '0;
		end else begin
			len_q   <= len_n;
			phase_q <= phase_n;
			if (cmd.load) begin
				len_q   <= '0;
				phase_q <= '0;
			end
			if (cmd.emit_init) k_q <= '0;
			else if (cmd.emit_step) k_q <= next_k;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= req.magnitude;
			neg_q   <= !req.non_negative && req.magnitude != 32'd0;
			base_q  <= base_c;
			fl_q    <= req.format_flags;
			width_q <= req.field_width;
			prec_q  <= req.min_digits;
			pos_q   <= req.start_pos;
		end else if (div_done) begin
			mag_q <= quo;
		end
		if (cmd.emit_init) begin
			logic [6:0] pre;
			logic [6:0] tot;
			pre = 7'd0;
			if (!fl_q[itf_pkg::FL_LEFT] && !fl_q[itf_pkg::FL_ZERO] && 7'(len_q) < 7'(width_eff))
				pre = 7'(width_eff) - 7'(len_q);
			tot = 7'(len_q) + pre;
			if (fl_q[itf_pkg::FL_LEFT] && tot < 7'(width_q)) tot = 7'(width_q);
			pre_q   <= pre;
			total_q <= tot;
		end
	end

	// read address for the character at index k, or at k+1 while stepping
	assign next_k = k_q + 7'd1;
	assign kmp = (cmd.emit_step ? next_k : k_q) - pre_q;
	assign ridx = 7'(len_q) - 7'd1 - kmp;

	logic [6:0] ck;
	assign ck = k_q - pre_q;
	assign beat.out_char = (k_q < pre_q || ck >= 7'(len_q)) ? itf_pkg::CH_SPACE : rd_q;
	assign beat.out_pos = pos_q + 16'(k_q);
	assign beat.last_char = (k_q + 7'd1 == total_q);

	assign sts.div_done    = div_done;
	assign sts.digits_done = (mag_q == 32'd0 && len_q != '0) || len_q == BSZ;
	assign sts.pad_done    = (phase_q == 3'd6);
	assign sts.emit_last   = beat.last_char;
endmodule
`default_nettype wire

### rtl/core/itf_ctrl.sv
// Controller: sequences digit generation, padding and character emission.
`timescale 1ns / 1ps
`default_nettype none
module itf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire logic             zero_mag,
	input  wire itf_pkg::dp_sts_t sts,
	output itf_pkg::dp_cmd_t      cmd
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_DIV   = 7'b0000100,
		S_PAD   = 7'b0001000,
		S_INIT  = 7'b0010000,
		S_FETCH = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q, state_n;
	logic   zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (in_valid && in_ready) zero_q <= zero_mag;
			else if (cmd.push_digit) zero_q <= 1'b0;
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (zero_q) begin
					cmd.push_digit = 1'b1;
					state_n        = S_PAD;
				end else if (sts.digits_done) begin
					state_n = S_PAD;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.push_digit = 1'b1;
					state_n        = S_CHECK;
				end
			end
			S_PAD: begin
				if (sts.pad_done) state_n = S_INIT;
				else cmd.pad_step = 1'b1;
			end
			S_INIT: begin
				cmd.emit_init = 1'b1;
				state_n       = S_FETCH;
			end
			S_FETCH: state_n = S_EMIT;
			S_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.emit_last) state_n = S_IDLE;
					else begin
						cmd.emit_step = 1'b1;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
